/* hdl/rbsi_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the ray/box slab intersection unit.
// No dependencies; imported by every module of the block.
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

endpackage

/* hdl/rbsi_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rbsi_pkg; the caller supplies a global advance enable.
module rbsi_div import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [COORD_WIDTH+1:0]               i_num,
    input  logic [COORD_WIDTH-1:0]               i_den,
    output logic [COORD_WIDTH+FRAC_BITS+1:0]     o_quo
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F + 2;

    logic [W-1:0]  r_rem [QW];
    logic [QW-1:0] r_aq  [QW];
    logic [W-1:0]  r_den [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [W-1:0]  rem_i;
        logic [QW-1:0] aq_i;
        logic [W-1:0]  den_i;
        logic [W:0]    trial;
        logic [W:0]    diff;
        logic          ge;
        logic [W-1:0]  n_rem;
        logic [QW-1:0] n_aq;

        if (j == 0) begin : g_first
            assign rem_i = '0;
            assign aq_i  = {i_num, {F{1'b0}}};
            assign den_i = i_den;
        end else begin : g_next
            assign rem_i = r_rem[j-1];
            assign aq_i  = r_aq[j-1];
            assign den_i = r_den[j-1];
        end

        assign trial = {rem_i, aq_i[QW-1]};
        assign diff  = trial - {1'b0, den_i};
        assign ge    = trial >= {1'b0, den_i};
        assign n_rem = ge ? diff[W-1:0] : trial[W-1:0];
        assign n_aq  = {aq_i[QW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_aq[j]  <= n_aq;
                r_den[j] <= den_i;
            end
        end
    end

    assign o_quo = r_aq[QW-1];

endmodule

/* hdl/rbsi_pt.sv */
`timescale 1ns / 1ps
// Point evaluation origin + dir*t: split multiply, shift, saturating add.
// Depends on rbsi_pkg; three register stages under a global enable.
module rbsi_pt import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [COORD_WIDTH-1:0] i_org,
    input  logic [COORD_WIDTH-1:0] i_dir,
    input  logic [COORD_WIDTH-1:0] i_t,
    output logic [COORD_WIDTH-1:0] o_pt,
    output logic                   o_clip
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int H  = W / 2;
    localparam int HB = W - H;
    localparam int MW = 2 * W - F;
    localparam int SW = MW + 2;

    logic [W:0]      dir_ext, t_ext, dir_abs, t_abs;
    logic [W-1:0]    dmag, tmag;
    logic [W+H-1:0]  n_pl;
    logic [W+HB-1:0] n_ph;

    logic [W+H-1:0]  r_pl;
    logic [W+HB-1:0] r_ph;
    logic            r_neg_a, r_neg_b;
    logic [W-1:0]    r_org_a, r_org_b;
    logic [MW-1:0]   r_m;

    logic [2*W-1:0]        full;
    logic signed [SW-1:0]  sorg, sm, sum, lim_hi, lim_lo;
    logic [W-1:0]          n_pt;
    logic                  n_clip;

    assign dir_ext = {i_dir[W-1], i_dir};
    assign t_ext   = {i_t[W-1], i_t};
    assign dir_abs = i_dir[W-1] ? -dir_ext : dir_ext;
    assign t_abs   = i_t[W-1] ? -t_ext : t_ext;
    assign dmag    = dir_abs[W-1:0];
    assign tmag    = t_abs[W-1:0];
    assign n_pl    = {{H{1'b0}}, dmag} * {{W{1'b0}}, tmag[H-1:0]};
    assign n_ph    = {{HB{1'b0}}, dmag} * {{W{1'b0}}, tmag[W-1:H]};

    assign full = {r_ph, {H{1'b0}}} + {{HB{1'b0}}, r_pl};

    assign sorg   = {{(SW-W){r_org_b[W-1]}}, r_org_b};
    assign sm     = {2'b00, r_m};
    assign sum    = r_neg_b ? (sorg - sm) : (sorg + sm);
    assign lim_hi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    assign lim_lo = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    always_comb begin
        n_clip = 1'b0;
        n_pt   = sum[W-1:0];
        if (sum > lim_hi) begin
            n_clip = 1'b1;
            n_pt   = lim_hi[W-1:0];
        end else if (sum < lim_lo) begin
            n_clip = 1'b1;
            n_pt   = lim_lo[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl    <= n_pl;
            r_ph    <= n_ph;
            r_neg_a <= i_dir[W-1] ^ i_t[W-1];
            r_org_a <= i_org;
            r_m     <= full[2*W-1:F];
            r_neg_b <= r_neg_a;
            r_org_b <= r_org_a;
            o_pt    <= n_pt;
            o_clip  <= n_clip;
        end
    end

endmodule

/* hdl/ray_box_slab_intersection_unit.sv */
`timescale 1ns / 1ps
// Top level of the ray/box slab intersection unit.
// Depends on rbsi_pkg, rbsi_div and rbsi_pt.

// Accepts one ray/box item per clock, unless the output buffer is full and not
// read, and returns one result per item in order. Each item passes through the
// six restoring dividers that resolve one quotient bit per pipeline stage, then
// t selection and the split multiplier of the point stage. The pipeline advances
// as a whole; a two-entry output buffer keeps input flowing while a result waits.
// Sustained rate is one item per cycle while the output is accepted.
module ray_box_slab_intersection_unit import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, box_corner_x/y/z, box_extent_x/y/z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // entry_x/y/z, exit_x/y/z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata,
    // zero_direction, clipped
    output logic [1:0]                          o_m_axis_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int QW    = W + F + 2;
    localparam int OUTW  = ((6*W+7)/8)*8;
    localparam int S_QF  = QW + 2;
    localparam int S_LH  = QW + 3;
    localparam int S_M1  = QW + 4;
    localparam int S_M2  = QW + 5;
    localparam int L     = QW + 9;

    typedef struct packed {
        logic [2:0][W-1:0] org;
        logic [2:0][W-1:0] dir;
        logic [5:0]        nneg;
        logic [5:0]        nzero;
        logic              zero;
        logic              clip;
    } t_side;

    typedef struct packed {
        logic [5:0][W-1:0] pt;
        logic              zero;
        logic              clip;
    } t_res;

    logic        en;
    logic [L-1:0] r_v;
    t_side       r_side [L];
    t_side       n_side [L];

    logic [W-1:0]  r_cor [3];
    logic [W-1:0]  r_ext [3];
    logic [W+1:0]  r_nmag [3][2];
    logic [W-1:0]  r_dmag [3];
    logic [QW-1:0] quo [3][2];
    logic signed [W-1:0] r_t [3][2];
    logic signed [W-1:0] r_lo [3];
    logic signed [W-1:0] r_hi [3];
    logic signed [W-1:0] r_n01, r_f01, r_lo2, r_hi2, r_tn, r_tf;

    logic [W+1:0]  n_nmag [3][2];
    logic [2:0][1:0] n_nneg, n_nzero;
    logic [W-1:0]  n_dmag [3];
    logic [2:0]    dzero;
    logic signed [W-1:0] n_t [3][2];
    logic [5:0]    qclip;

    logic [W-1:0]  pt_near [3];
    logic [W-1:0]  pt_far  [3];
    logic [5:0]    pt_clip;

    t_res        r_mem [2];
    t_res        res_in;
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    localparam logic [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};

    assign en              = (r_cnt != 2'd2) || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // numerators and magnitudes
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [W+1:0] org_e, cor_e, ext_e, num1, num2, abs1, abs2;
            logic [W:0]   dir_e, dabs;
            org_e = {{2{r_side[0].org[a][W-1]}}, r_side[0].org[a]};
            cor_e = {{2{r_cor[a][W-1]}}, r_cor[a]};
            ext_e = {{2{r_ext[a][W-1]}}, r_ext[a]};
            num1  = cor_e - org_e;
            num2  = cor_e + ext_e - org_e;
            abs1  = num1[W+1] ? -num1 : num1;
            abs2  = num2[W+1] ? -num2 : num2;
            n_nmag[a][0]  = abs1;
            n_nmag[a][1]  = abs2;
            n_nneg[a][0]  = num1[W+1];
            n_nneg[a][1]  = num2[W+1];
            n_nzero[a][0] = num1 == '0;
            n_nzero[a][1] = num2 == '0;
            dir_e = {r_side[0].dir[a][W-1], r_side[0].dir[a]};
            dabs  = r_side[0].dir[a][W-1] ? -dir_e : dir_e;
            n_dmag[a] = dabs[W-1:0];
            dzero[a]  = r_side[0].dir[a] == '0;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        for (genvar s = 0; s < 2; s++) begin : g_slab
            rbsi_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_nmag[a][s]),
                .i_den (r_dmag[a]),
                .o_quo (quo[a][s])
            );
        end
        rbsi_pt #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_pt_near (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_org  (r_side[S_M2].org[a]),
            .i_dir  (r_side[S_M2].dir[a]),
            .i_t    (r_tn),
            .o_pt   (pt_near[a]),
            .o_clip (pt_clip[a])
        );
        rbsi_pt #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_pt_far (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_org  (r_side[S_M2].org[a]),
            .i_dir  (r_side[S_M2].dir[a]),
            .i_t    (r_tf),
            .o_pt   (pt_far[a]),
            .o_clip (pt_clip[3+a])
        );
    end

    // quotient sign, saturation and zero-direction substitution
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < 2; s++) begin
                logic [QW-1:0] q;
                logic          neg, nn, nz;
                q   = quo[a][s];
                nn  = r_side[S_QF-1].nneg[2*a+s];
                nz  = r_side[S_QF-1].nzero[2*a+s];
                neg = nn ^ r_side[S_QF-1].dir[a][W-1];
                qclip[2*a+s] = 1'b0;
                if (r_side[S_QF-1].dir[a] == '0) begin
                    n_t[a][s] = nz ? '0 : (nn ? T_MIN : T_MAX);
                end else if (!neg) begin
                    if (|q[QW-1:W-1]) begin
                        n_t[a][s] = T_MAX;
                        qclip[2*a+s] = 1'b1;
                    end else begin
                        n_t[a][s] = q[W-1:0];
                    end
                end else begin
                    if ((|q[QW-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
                        n_t[a][s] = T_MIN;
                        qclip[2*a+s] = 1'b1;
                    end else begin
                        n_t[a][s] = -q[W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        n_side[0] = r_side[0];
        for (int k = 1; k < L; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[1].zero  = |dzero;
        n_side[1].nneg  = n_nneg;
        n_side[1].nzero = n_nzero;
        n_side[S_QF].clip = r_side[S_QF-1].clip | (|qclip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[L-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_side[0].org[a] <= i_s_axis_tdata[a*W +: W];
                r_side[0].dir[a] <= i_s_axis_tdata[(3+a)*W +: W];
                r_cor[a]         <= i_s_axis_tdata[(6+a)*W +: W];
                r_ext[a]         <= i_s_axis_tdata[(9+a)*W +: W];
                r_dmag[a]        <= n_dmag[a];
                r_nmag[a][0]     <= n_nmag[a][0];
                r_nmag[a][1]     <= n_nmag[a][1];
                r_t[a][0]        <= n_t[a][0];
                r_t[a][1]        <= n_t[a][1];
                r_lo[a] <= (r_t[a][0] < r_t[a][1]) ? r_t[a][0] : r_t[a][1];
                r_hi[a] <= (r_t[a][0] < r_t[a][1]) ? r_t[a][1] : r_t[a][0];
            end
            r_side[0].nneg  <= '0;
            r_side[0].nzero <= '0;
            r_side[0].zero  <= 1'b0;
            r_side[0].clip  <= 1'b0;
            for (int k = 1; k < L; k++) begin
                r_side[k] <= n_side[k];
            end
            r_n01 <= (r_lo[1] > r_lo[0]) ? r_lo[1] : r_lo[0];
            r_f01 <= (r_hi[1] < r_hi[0]) ? r_hi[1] : r_hi[0];
            r_lo2 <= r_lo[2];
            r_hi2 <= r_hi[2];
            r_tn  <= (r_lo2 > r_n01) ? r_lo2 : r_n01;
            r_tf  <= (r_hi2 < r_f01) ? r_hi2 : r_f01;
        end
    end

    // output buffer
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            res_in.pt[a]   = pt_near[a];
            res_in.pt[3+a] = pt_far[a];
        end
        res_in.zero = r_side[L-1].zero;
        res_in.clip = r_side[L-1].clip | (|pt_clip);
    end

    assign push = en && r_v[L-1];
    assign pop  = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= res_in;
        end
    end

    assign o_m_axis_tvalid = r_cnt != '0;
    assign o_m_axis_tdata  = OUTW'(r_mem[r_rp].pt);
    assign o_m_axis_tuser  = {r_mem[r_rp].clip, r_mem[r_rp].zero};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output buffer overfilled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipeline moved while stalled");

    a_accept_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[0])
        else $error("accepted transfer not captured");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && push) |-> pop)
        else $error("push into full output buffer");

endmodule
